/* hw/rtl/bfs_pkg.sv */
package bfs_pkg;

  localparam int unsigned GridCols   = 80;
  localparam int unsigned GridRows   = 25;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned RowW       = 5;
  localparam int unsigned ColW       = 7;
  localparam int unsigned DataW      = 32;

  typedef enum logic [1:0] {
    DirLeft  = 2'd0,
    DirRight = 2'd1,
    DirUp    = 2'd2,
    DirDown  = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    ModeLoad    = 2'd0,
    ModeExec    = 2'd1,
    ModeRestart = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvNum   = 2'd1,
    EvChar  = 2'd2,
    EvHalt  = 2'd3
  } event_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDol   = 8'h24;
  localparam logic [7:0] ChMod   = 8'h25;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChMul   = 8'h2a;
  localparam logic [7:0] ChAdd   = 8'h2b;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChSub   = 8'h2d;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChDiv   = 8'h2f;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChLt    = 8'h3c;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChQmark = 8'h3f;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChBslash= 8'h5c;
  localparam logic [7:0] ChCaret = 8'h5e;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChTick  = 8'h60;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChPipe  = 8'h7c;
  localparam logic [7:0] ChTilde = 8'h7e;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChSpace = 8'h20;

  // controller states
  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StFetch,
    StPop1,
    StPop2,
    StPop3,
    StExec,
    StDiv,
    StGet,
    StPut,
    StPush1,
    StPush2,
    StOut
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic clr_step;
    logic take_item;
    logic fetch;
    logic pop;
    logic exec;
    logic div_start;
    logic get_rd;
    logic put_wr;
    logic push_a;
    logic push_b;
    logic finish;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic clr_done;
    logic is_exec;
    logic is_other;
    logic halted;
    logic [1:0] pops;
    logic need_div;
    logic need_get;
    logic need_put;
    logic [1:0] pushes;
    logic div_done;
  } stat_t;

endpackage

/* hw/rtl/bfs_div.sv */
// Signed restoring divider, one quotient bit per cycle.
module bfs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] q_q, q_d, r_q, r_d, dv_q, dv_d;
  logic        qneg_q, qneg_d, rneg_q, rneg_d;
  logic [32:0] trial;

  assign trial  = {r_q, q_q[31]} - {1'b0, dv_q};
  assign done_o = busy_q && (cnt_q == 6'd32);
  assign quo_o  = qneg_q ? -q_q : q_q;
  assign rem_o  = rneg_q ? -r_q : r_q;

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; q_d = q_q; r_d = r_q; dv_d = dv_q;
    qneg_d = qneg_q; rneg_d = rneg_q;
    if (start_i) begin
      busy_d = 1'b1; cnt_d = '0; r_d = '0;
      q_d    = num_i[31] ? -num_i : num_i;
      dv_d   = den_i[31] ? -den_i : den_i;
      qneg_d = num_i[31] ^ den_i[31];
      rneg_d = num_i[31];
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 6'd1;
      if (!trial[32]) begin
        r_d = trial[31:0]; q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = {r_q[30:0], q_q[31]}; q_d = {q_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; dv_q <= dv_d; qneg_q <= qneg_d; rneg_q <= rneg_d;
  end

endmodule

/* hw/rtl/bfs_ctrl.sv */
module bfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bfs_pkg::stat_t stat_i,
  output bfs_pkg::cmd_t  cmd_o
);

  bfs_pkg::state_e state_q, state_d;
  logic [1:0] popn_q, popn_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfs_pkg::StClear;
      popn_q  <= '0;
    end else begin
      state_q <= state_d;
      popn_q  <= popn_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    popn_d      = popn_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      bfs_pkg::StClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = bfs_pkg::StIdle;
      end
      bfs_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d = bfs_pkg::StFetch;
        end
      end
      bfs_pkg::StFetch: begin
        // grid byte read is registered; decode next
        cmd_o.fetch = 1'b1;
        state_d = bfs_pkg::StPop1;
      end
      bfs_pkg::StPop1: begin
        if (!stat_i.is_exec || stat_i.halted) begin
          state_d = bfs_pkg::StOut;
          cmd_o.finish = 1'b1;
        end else if (stat_i.pops != 2'd0) begin
          cmd_o.pop = 1'b1;
          popn_d = stat_i.pops - 2'd1;
          state_d = (stat_i.pops == 2'd1) ? bfs_pkg::StExec : bfs_pkg::StPop2;
        end else begin
          state_d = bfs_pkg::StExec;
        end
      end
      bfs_pkg::StPop2: begin
        cmd_o.pop = 1'b1;
        popn_d = popn_q - 2'd1;
        state_d = (popn_q == 2'd1) ? bfs_pkg::StExec : bfs_pkg::StPop3;
      end
      bfs_pkg::StPop3: begin
        cmd_o.pop = 1'b1;
        state_d = bfs_pkg::StExec;
      end
      bfs_pkg::StExec: begin
        cmd_o.exec = 1'b1;
        if (stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = bfs_pkg::StDiv;
        end else if (stat_i.need_get) begin
          state_d = bfs_pkg::StGet;
        end else if (stat_i.need_put) begin
          state_d = bfs_pkg::StPut;
        end else if (stat_i.pushes != 2'd0) begin
          state_d = bfs_pkg::StPush1;
        end else begin
          cmd_o.finish = 1'b1;
          state_d = bfs_pkg::StOut;
        end
      end
      bfs_pkg::StDiv: begin
        if (stat_i.div_done) state_d = bfs_pkg::StPush1;
      end
      bfs_pkg::StGet: begin
        cmd_o.get_rd = 1'b1;
        state_d = bfs_pkg::StPush1;
      end
      bfs_pkg::StPut: begin
        cmd_o.put_wr = 1'b1;
        cmd_o.finish = 1'b1;
        state_d = bfs_pkg::StOut;
      end
      bfs_pkg::StPush1: begin
        cmd_o.push_a = 1'b1;
        if (stat_i.pushes == 2'd2) begin
          state_d = bfs_pkg::StPush2;
        end else begin
          cmd_o.finish = 1'b1;
          state_d = bfs_pkg::StOut;
        end
      end
      bfs_pkg::StPush2: begin
        cmd_o.push_b = 1'b1;
        cmd_o.finish = 1'b1;
        state_d = bfs_pkg::StOut;
      end
      bfs_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = bfs_pkg::StIdle;
      end
      default: state_d = bfs_pkg::StIdle;
    endcase
  end

endmodule

/* hw/rtl/bfs_dp.sv */
module bfs_dp #(
  parameter int unsigned GRID_COLS   = bfs_pkg::GridCols,
  parameter int unsigned GRID_ROWS   = bfs_pkg::GridRows,
  parameter int unsigned STACK_DEPTH = bfs_pkg::StackDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic [55:0]          item_i,
  input  bfs_pkg::cmd_t        cmd_i,
  output bfs_pkg::stat_t       stat_o,
  output logic [1:0]           event_o,
  output logic [31:0]          value_o,
  output logic                 err_o
);

  localparam int unsigned Cells = GRID_COLS * GRID_ROWS;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned SW    = $clog2(STACK_DEPTH);
  localparam int unsigned CW    = $clog2(STACK_DEPTH + 1);

  logic [7:0]  grid_mem [Cells];
  logic [31:0] stk_mem  [STACK_DEPTH];

  logic [4:0]    rowcfg_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [6:0]    pcc_q, pcc_d;
  logic [4:0]    pcr_q, pcr_d;
  logic [1:0]    dir_q, dir_d;
  logic          str_q, str_d, halt_q, halt_d;
  logic [AW-1:0] clr_q;

  logic [55:0]   it_q;
  logic [7:0]    gdat_q;
  logic [31:0]   sdat_q;
  logic [31:0]   a_q, b_q, v_q, ra_q, rb_q;
  logic [1:0]    popi_q;
  logic [1:0]    ev_q;
  logic [31:0]   val_q;
  logic          err_q;
  logic [AW-1:0] gaddr_q;

  logic [1:0]    mode;
  logic [4:0]    crow;
  logic [6:0]    ccol;
  logic [7:0]    cval;
  logic [1:0]    rdir;
  logic [31:0]   ival;
  assign mode = it_q[1:0];
  assign crow = it_q[6:2];
  assign ccol = it_q[13:7];
  assign cval = it_q[21:14];
  assign rdir = it_q[23:22];
  assign ival = it_q[55:24];

  logic [5:0] rows;
  always_comb begin
    rows = {1'b0, rowcfg_q};
    if (rowcfg_q == 5'd0) rows = 6'd1;
    if ({1'b0, rowcfg_q} > 6'(GRID_ROWS)) rows = 6'(GRID_ROWS);
  end

  logic [7:0] op;
  assign op = gdat_q;
  logic is_digit, is_bin, is_div;
  assign is_digit = (op >= bfs_pkg::ChZero) && (op <= bfs_pkg::ChNine);
  assign is_bin = (op == bfs_pkg::ChAdd) || (op == bfs_pkg::ChSub) || (op == bfs_pkg::ChMul)
               || (op == bfs_pkg::ChDiv) || (op == bfs_pkg::ChMod) || (op == bfs_pkg::ChTick);
  assign is_div = (op == bfs_pkg::ChDiv) || (op == bfs_pkg::ChMod);

  // operands needed by this op
  logic [1:0] need;
  always_comb begin
    need = 2'd0;
    if (!str_q && !is_digit) begin
      if (is_bin || op == bfs_pkg::ChBslash || op == bfs_pkg::ChG) need = 2'd2;
      else if (op == bfs_pkg::ChP) need = 2'd3;
      else if (op == bfs_pkg::ChUnder || op == bfs_pkg::ChPipe || op == bfs_pkg::ChBang
            || op == bfs_pkg::ChDol || op == bfs_pkg::ChDot || op == bfs_pkg::ChComma)
        need = 2'd1;
    end
  end
  // stack depth as it was before this item's pops
  logic [CW-1:0] cnt_pre;
  assign cnt_pre = cnt_q + CW'(popi_q);
  logic enough;
  assign enough = cnt_pre >= CW'(need);

  // dup: pop the top, push it back twice
  logic is_dup;
  assign is_dup = !str_q && (op == bfs_pkg::ChColon);
  logic [1:0] pops;
  assign pops = !enough ? 2'd0 : (is_dup && cnt_q != '0) ? 2'd1 : need;

  // get/put range
  logic gp_ok;
  logic [5:0] rsel;
  logic [6:0] csel;
  assign gp_ok = ($signed(a_q) >= 0) && (a_q < 32'(rows))
              && ($signed(b_q) >= 0) && (b_q < 32'(GRID_COLS));
  assign rsel  = a_q[5:0];
  assign csel  = b_q[6:0];

  logic [31:0] quo, rem;
  logic        div_done;
  bfs_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .num_i  (b_q),
    .den_i  (a_q),
    .done_o (div_done),
    .quo_o  (quo),
    .rem_o  (rem)
  );

  // pushes and routing, decided in exec
  logic [1:0] npush;
  always_comb begin
    npush = 2'd0;
    if (str_q) npush = (op == bfs_pkg::ChQuote) ? 2'd0 : 2'd1;
    else if (is_digit || op == bfs_pkg::ChAmp || op == bfs_pkg::ChTilde) npush = 2'd1;
    else if (enough && (is_bin || op == bfs_pkg::ChBang || op == bfs_pkg::ChG)) npush = 2'd1;
    else if (enough && cnt_pre != '0 && (op == bfs_pkg::ChColon || op == bfs_pkg::ChBslash))
      npush = 2'd2;
  end

  logic ex_div, ex_get, ex_put;
  assign ex_div = !str_q && enough && is_div && (a_q != '0);
  assign ex_get = !str_q && enough && (op == bfs_pkg::ChG) && gp_ok;
  assign ex_put = !str_q && enough && (op == bfs_pkg::ChP) && gp_ok;

  always_comb begin
    stat_o          = '0;
    stat_o.clr_done = (clr_q == AW'(Cells - 1));
    stat_o.is_exec  = (mode == bfs_pkg::ModeExec);
    stat_o.halted   = halt_q;
    stat_o.pops     = pops;
    stat_o.need_div = ex_div;
    stat_o.need_get = ex_get;
    stat_o.need_put = ex_put;
    stat_o.pushes   = npush;
    stat_o.div_done = div_done;
    stat_o.is_other = (mode != bfs_pkg::ModeExec);
  end

  // advance
  function automatic logic [11:0] adv(input logic [6:0] c, input logic [4:0] r,
                                      input logic [1:0] d, input logic [5:0] rw);
    logic [6:0] nc;
    logic [4:0] nr;
    nc = c; nr = r;
    case (d)
      bfs_pkg::DirRight: nc = (8'(c) + 8'd1 >= 8'(GRID_COLS)) ? 7'd0 : c + 7'd1;
      bfs_pkg::DirLeft:  nc = (c == 7'd0 || 8'(c) > 8'(GRID_COLS)) ? 7'(GRID_COLS - 1)
                                                                      : c - 7'd1;
      bfs_pkg::DirDown:  nr = (6'(r) + 6'd1 >= rw) ? 5'd0 : r + 5'd1;
      default:           nr = (r == 5'd0 || 6'(r) > rw) ? 5'(rw - 6'd1) : r - 5'd1;
    endcase
    return {nc, nr};
  endfunction

  logic [11:0] adv1, adv2;
  assign adv1 = adv(pcc_q, pcr_q, dir_q, rows);
  assign adv2 = adv(adv1[11:5], adv1[4:0], dir_q, rows);

  // grid address of the pc / load / get-put cell
  logic [AW-1:0] pc_addr, ld_addr, gp_addr;
  assign pc_addr = AW'(pcr_q) * AW'(GRID_COLS) + AW'(pcc_q);
  assign ld_addr = AW'(crow) * AW'(GRID_COLS) + AW'(ccol);
  assign gp_addr = AW'(rsel) * AW'(GRID_COLS) + AW'(csel);

  logic pc_in;
  assign pc_in = (32'(pcr_q) < 32'(GRID_ROWS)) && (32'(pcc_q) < 32'(GRID_COLS));

  // binary result (non-divide)
  logic [31:0] bin_res;
  always_comb begin
    case (op)
      bfs_pkg::ChAdd: bin_res = b_q + a_q;
      bfs_pkg::ChSub: bin_res = b_q - a_q;
      bfs_pkg::ChMul: bin_res = b_q * a_q;
      bfs_pkg::ChTick: bin_res = {31'd0, $signed(b_q) > $signed(a_q)};
      default: bin_res = '0;
    endcase
  end

  // grid memory; the get cell is addressed during exec so its byte is ready in the get step
  logic          g_we;
  logic [AW-1:0] g_wa, g_ra;
  logic [7:0]    g_wd;
  always_comb begin
    g_we = 1'b0; g_wa = ld_addr; g_wd = cval;
    if (cmd_i.clr_step) begin
      g_we = 1'b1; g_wa = clr_q; g_wd = bfs_pkg::ChSpace;
    end else if (cmd_i.fetch && mode == bfs_pkg::ModeLoad) begin
      g_we = (32'(crow) < 32'(GRID_ROWS)) && (32'(ccol) < 32'(GRID_COLS));
    end else if (cmd_i.put_wr) begin
      g_we = 1'b1; g_wa = gaddr_q; g_wd = v_q[7:0];
    end
    g_ra = cmd_i.exec ? gp_addr : pc_addr;
  end
  logic [7:0] g_rd_q;
  always_ff @(posedge clk_i) begin
    if (g_we) grid_mem[g_wa] <= g_wd;
    g_rd_q <= grid_mem[g_ra];
  end

  // stack memory; read address follows the next count so the read data
  // holds the current top, except just after a push (read-before-write)
  logic          s_we;
  logic [SW-1:0] s_wa, s_ra;
  logic [31:0]   s_wd;
  always_comb begin
    s_we = 1'b0; s_wa = cnt_q[SW-1:0]; s_wd = ra_q;
    if ((cmd_i.push_a || cmd_i.push_b) && cnt_q < CW'(STACK_DEPTH)) s_we = 1'b1;
    if (cmd_i.push_b) s_wd = rb_q;
    s_ra = cnt_d[SW-1:0] - SW'(1);
  end
  always_ff @(posedge clk_i) begin
    if (s_we) stk_mem[s_wa] <= s_wd;
    sdat_q <= stk_mem[s_ra];
  end

  always_comb begin
    cnt_d = cnt_q; pcc_d = pcc_q; pcr_d = pcr_q; dir_d = dir_q;
    str_d = str_q; halt_d = halt_q;
    if (cmd_i.fetch) begin
      if (mode == bfs_pkg::ModeRestart) begin
        str_d = 1'b0; halt_d = 1'b0; dir_d = bfs_pkg::DirRight;
        pcc_d = '0; pcr_d = '0;
      end
    end
    if (cmd_i.pop) cnt_d = cnt_q - CW'(1);
    if ((cmd_i.push_a || cmd_i.push_b) && cnt_q < CW'(STACK_DEPTH)) cnt_d = cnt_q + CW'(1);
    if (cmd_i.exec) begin
      if (str_q) begin
        if (op == bfs_pkg::ChQuote) str_d = 1'b0;
      end else begin
        case (op)
          bfs_pkg::ChLt:    dir_d = bfs_pkg::DirLeft;
          bfs_pkg::ChGt:    dir_d = bfs_pkg::DirRight;
          bfs_pkg::ChCaret: dir_d = bfs_pkg::DirUp;
          bfs_pkg::ChV:     dir_d = bfs_pkg::DirDown;
          bfs_pkg::ChQmark: dir_d = rdir;
          bfs_pkg::ChUnder: if (enough) dir_d = (a_q == '0) ? bfs_pkg::DirRight
                                                               : bfs_pkg::DirLeft;
          bfs_pkg::ChPipe:  if (enough) dir_d = (a_q == '0) ? bfs_pkg::DirDown
                                                               : bfs_pkg::DirUp;
          bfs_pkg::ChQuote: str_d = 1'b1;
          bfs_pkg::ChAt:    halt_d = 1'b1;
          default: ;
        endcase
      end
    end
  end

  logic pc_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowcfg_q <= 5'd25;
      cnt_q <= '0; pcc_q <= '0; pcr_q <= '0; dir_q <= bfs_pkg::DirRight;
      str_q <= 1'b0; halt_q <= 1'b0; clr_q <= '0;
    end else begin
      if (cfg_we_i) rowcfg_q <= cfg_wdata_i;
      if (cmd_i.clr_step) clr_q <= clr_q + AW'(1);
      cnt_q <= cnt_d; str_q <= str_d; halt_q <= halt_d; dir_q <= dir_d;
      if (pc_move) begin
        pcc_q <= (!str_q && op == bfs_pkg::ChHash) ? adv2[11:5] : adv1[11:5];
        pcr_q <= (!str_q && op == bfs_pkg::ChHash) ? adv2[4:0] : adv1[4:0];
      end else begin
        pcc_q <= pcc_d; pcr_q <= pcr_d;
      end
    end
  end
  // pointer moves once per executed instruction, after the heading update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pc_move <= 1'b0;
    else pc_move <= cmd_i.exec;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      it_q <= item_i; ev_q <= bfs_pkg::EvNone; val_q <= '0; err_q <= 1'b0;
      popi_q <= '0;
    end
    if (cmd_i.fetch) gdat_q <= pc_in ? g_rd_q : bfs_pkg::ChSpace;
    if (cmd_i.pop) begin
      // first pop is a, second b, third v
      case (popi_q)
        2'd0: a_q <= sdat_q;
        2'd1: b_q <= sdat_q;
        default: v_q <= sdat_q;
      endcase
      popi_q <= popi_q + 2'd1;
    end
    if (cmd_i.exec) begin
      gaddr_q <= gp_addr;
      ra_q <= '0; rb_q <= '0;
      if (str_q) ra_q <= {24'd0, op};
      else if (is_digit) ra_q <= {28'd0, op[3:0]};
      else if (op == bfs_pkg::ChAmp || op == bfs_pkg::ChTilde) ra_q <= ival;
      else if (is_bin) ra_q <= bin_res;
      else if (op == bfs_pkg::ChBang) ra_q <= {31'd0, a_q == '0};
      else if (op == bfs_pkg::ChColon) begin ra_q <= a_q; rb_q <= a_q; end
      else if (op == bfs_pkg::ChBslash) begin ra_q <= a_q; rb_q <= b_q; end
      if (!str_q && enough && (op == bfs_pkg::ChDot || op == bfs_pkg::ChComma)) begin
        val_q <= a_q;
        ev_q  <= (op == bfs_pkg::ChDot) ? bfs_pkg::EvNum : bfs_pkg::EvChar;
      end
      if (!str_q && op == bfs_pkg::ChAt) ev_q <= bfs_pkg::EvHalt;
    end
    if (div_done) ra_q <= (op == bfs_pkg::ChDiv) ? quo : rem;
    if (cmd_i.get_rd) ra_q <= {24'd0, g_rd_q};
    if ((cmd_i.push_a || cmd_i.push_b) && cnt_q >= CW'(STACK_DEPTH)) err_q <= 1'b1;
    if (cmd_i.fetch && mode == bfs_pkg::ModeExec && halt_q) ev_q <= bfs_pkg::EvHalt;
  end

  assign event_o = ev_q;
  assign value_o = val_q;
  assign err_o   = err_q;

endmodule

/* hw/rtl/befunge_step_core_top.sv */
// Befunge-93 single-step engine. Each input beat loads one grid cell
// (mode 0), executes one instruction at the pointer (mode 1) or restarts
// (mode 2), and gives exactly one output beat with the print/halt event.
// An item runs grid fetch, up to three stack pops (one memory read each),
// execute and up to two pushes; / and % run a bit-serial divider, and g
// and p add one grid access. One item is in work at a time. After reset
// the grid is swept to spaces, one cell a cycle, before the first beat is
// accepted. row_count is written by cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, which the block itself does not enforce.
module befunge_step_core_top #(
  parameter int unsigned GRID_COLS   = bfs_pkg::GridCols,
  parameter int unsigned GRID_ROWS   = bfs_pkg::GridRows,
  parameter int unsigned STACK_DEPTH = bfs_pkg::StackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[1:0], cell_row[6:2], cell_col[13:7], cell_value[21:14],
  // random_dir[23:22], input_value[55:24]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // event_res[1:0], out_value[33:2], stack_error[34], zero fill above
  output logic [39:0] m_axis_tdata
);

  bfs_pkg::cmd_t  cmd;
  bfs_pkg::stat_t stat;
  logic [1:0]  ev;
  logic [31:0] val;
  logic        err;

  bfs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfs_dp #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .item_i (s_axis_tdata),
    .cmd_i  (cmd),
    .stat_o (stat),
    .event_o(ev),
    .value_o(val),
    .err_o  (err)
  );

  assign m_axis_tdata = {5'd0, err, val, ev};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import bfs_pkg::*;

  localparam int unsigned SettleCycles = 60;     // longest item incl. divider, with margin
  localparam int unsigned StallLimit   = 20000;  // covers the clearing sweep after reset

  typedef struct packed {
    logic [31:0] ival;
    logic [1:0]  rdir;
    logic [7:0]  val;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [1:0]  mode;
  } step_beat_t;

  typedef struct {
    event_e      ev;
    logic [31:0] outv;
    logic        dropped;
  } step_res_t;

  // directed rows: expected event/value typed only where obvious
  typedef struct {
    logic [1:0]  mode;
    logic [4:0]  row;
    logic [6:0]  col;
    logic [7:0]  val;
    logic [1:0]  rdir;
    logic [31:0] ival;
    bit          typed;
    event_e      ev;
    logic [31:0] outv;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  // program grid and interpreter registers as this bench sees them
  logic [7:0]  prog_grid [GridRows][GridCols];
  logic [31:0] val_stack [StackDepth];
  int unsigned stack_cnt;
  int unsigned pc_c, pc_r;
  dir_e        heading;
  bit          str_on, stopped, dropped;
  logic [4:0]  row_cfg;

  step_res_t   pending_res[$];
  int          n_err = 0;
  bit          calm = 1'b0;       // no idling on either side while set
  int unsigned quiet_cycles = 0;
  bit          s_beat, m_beat;

  befunge_step_core_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned rows_live();
    if (row_cfg == 0) return 1;
    if (row_cfg > GridRows) return GridRows;
    return row_cfg;
  endfunction

  function automatic void push_word(logic [31:0] v);
    if (stack_cnt < StackDepth) begin
      val_stack[stack_cnt] = v;
      stack_cnt++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  function automatic logic [31:0] pop_word();
    stack_cnt--;
    return val_stack[stack_cnt];
  endfunction

  function automatic void move_pc();
    int unsigned rows;
    rows = rows_live();
    case (heading)
      DirRight: pc_c = (pc_c + 1 >= GridCols) ? 0 : pc_c + 1;
      DirLeft:  pc_c = (pc_c == 0 || pc_c > GridCols) ? GridCols - 1 : pc_c - 1;
      DirDown:  pc_r = (pc_r + 1 >= rows) ? 0 : pc_r + 1;
      default:  pc_r = (pc_r == 0 || pc_r > rows) ? rows - 1 : pc_r - 1;
    endcase
  endfunction

  function automatic bit on_grid(logic [31:0] r, logic [31:0] c);
    return $signed(r) >= 0 && $signed(r) < int'(rows_live()) &&
           $signed(c) >= 0 && $signed(c) < int'(GridCols);
  endfunction

  function automatic logic [31:0] arith(logic [7:0] op, logic [31:0] a, logic [31:0] b);
    longint sa, sb;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    case (op)
      ChAdd:   return b + a;
      ChSub:   return b - a;
      ChMul:   return b * a;
      ChDiv:   return (sa == 0) ? 32'd0 : 32'(sb / sa);
      ChMod:   return (sa == 0) ? 32'd0 : 32'(sb % sa);
      default: return (sb > sa) ? 32'd1 : 32'd0;
    endcase
  endfunction

  // next interpreter step for one accepted beat
  function automatic step_res_t interp_step(step_beat_t b);
    step_res_t   r;
    logic [7:0]  op;
    logic [31:0] x, y, v;
    r.ev = EvNone;
    r.outv = '0;
    dropped = 1'b0;
    if (b.mode == ModeLoad) begin
      if (b.row < GridRows && b.col < GridCols) prog_grid[b.row][b.col] = b.val;
    end else if (b.mode == ModeRestart) begin
      str_on = 1'b0;
      stopped = 1'b0;
      heading = DirRight;
      pc_c = 0;
      pc_r = 0;
    end else if (b.mode == ModeExec) begin
      if (stopped) begin
        r.ev = EvHalt;
      end else begin
        op = prog_grid[pc_r][pc_c];
        if (str_on) begin
          if (op == ChQuote) str_on = 1'b0;
          else push_word({24'd0, op});
        end else if (op >= ChZero && op <= ChNine) begin
          push_word({24'd0, op - ChZero});
        end else begin
          case (op)
            ChAdd, ChSub, ChMul, ChDiv, ChMod, ChTick: begin
              if (stack_cnt >= 2) begin
                x = pop_word();
                y = pop_word();
                push_word(arith(op, x, y));
              end
            end
            ChLt:    heading = DirLeft;
            ChGt:    heading = DirRight;
            ChCaret: heading = DirUp;
            ChV:     heading = DirDown;
            ChQmark: heading = dir_e'(b.rdir);
            ChUnder: if (stack_cnt >= 1) heading = (pop_word() == 0) ? DirRight : DirLeft;
            ChPipe:  if (stack_cnt >= 1) heading = (pop_word() == 0) ? DirDown : DirUp;
            ChQuote: str_on = 1'b1;
            ChBang:  if (stack_cnt >= 1) push_word((pop_word() == 0) ? 32'd1 : 32'd0);
            ChColon: if (stack_cnt >= 1) push_word(val_stack[stack_cnt-1]);
            ChDol:   if (stack_cnt >= 1) void'(pop_word());
            ChBslash: begin
              if (stack_cnt >= 2) begin
                x = pop_word();
                y = pop_word();
                push_word(x);
                push_word(y);
              end
            end
            ChDot, ChComma: begin
              if (stack_cnt >= 1) begin
                r.outv = pop_word();
                r.ev = (op == ChDot) ? EvNum : EvChar;
              end
            end
            ChAmp, ChTilde: push_word(b.ival);
            ChG: begin
              if (stack_cnt >= 2) begin
                x = pop_word();
                y = pop_word();
                push_word(on_grid(x, y) ? {24'd0, prog_grid[x][y]} : 32'd0);
              end
            end
            ChP: begin
              if (stack_cnt >= 3) begin
                x = pop_word();
                y = pop_word();
                v = pop_word();
                if (on_grid(x, y)) prog_grid[x][y] = v[7:0];
              end
            end
            ChHash: move_pc();
            ChAt: begin
              stopped = 1'b1;
              r.ev = EvHalt;
            end
            default: ;
          endcase
        end
        move_pc();
      end
    end
    r.dropped = dropped;
    return r;
  endfunction

  // one input beat; typed_res overrides the predicted result when use_typed is set
  task automatic send_beat(step_beat_t b, bit use_typed = 1'b0, step_res_t typed_res = '{EvNone, 0, 0});
    int unsigned gap;
    step_res_t   r;
    gap = (calm || $urandom_range(99) >= 35) ? 0 : $urandom_range(1, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    r = interp_step(b);
    if (use_typed) r = typed_res;
    pending_res = {pending_res, r};
  endtask

  // row_count write: only once the core has drained
  task automatic write_rows(logic [4:0] v);
    s_tvalid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    row_cfg = v;
  endtask

  function automatic logic [7:0] pick_op();
    logic [7:0] pool [26] = '{ChAdd, ChSub, ChMul, ChDiv, ChMod, ChTick, ChLt, ChGt,
                              ChCaret, ChV, ChQmark, ChUnder, ChPipe, ChQuote, ChBang,
                              ChColon, ChDol, ChBslash, ChDot, ChComma, ChAmp, ChTilde,
                              ChG, ChP, ChHash, ChAt};
    int unsigned k;
    k = $urandom_range(99);
    if (k < 25) return ChZero + 8'($urandom_range(9));
    if (k < 30) return 8'($urandom_range(255));
    if (k < 35) return ChSpace;
    return pool[$urandom_range(25)];
  endfunction

  function automatic logic [31:0] pick_input();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 50) return $urandom_range(24);
    if (k < 70) return $urandom_range(79);
    if (k < 80) return -$urandom_range(1, 5);
    return $urandom;
  endfunction

  function automatic step_beat_t mk_beat(logic [1:0] mode, logic [4:0] row, logic [6:0] col,
                                         logic [7:0] val);
    step_beat_t b;
    b.mode = mode;
    b.row  = row;
    b.col  = col;
    b.val  = val;
    b.rdir = 2'($urandom_range(3));
    b.ival = pick_input();
    return b;
  endfunction

  // result side: random stalls, check every beat against the oldest expectation
  always @(posedge clk) begin
    step_res_t exp_r;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, m_tdata);
        n_err++;
      end else begin
        exp_r = pending_res.pop_front();
        if (m_tdata[1:0] !== exp_r.ev) begin
          $display("%0t: event expected %0d got %0d", $time, exp_r.ev, m_tdata[1:0]);
          n_err++;
        end
        if (m_tdata[33:2] !== exp_r.outv) begin
          $display("%0t: value expected %h got %h", $time, exp_r.outv, m_tdata[33:2]);
          n_err++;
        end
        if (m_tdata[34] !== exp_r.dropped) begin
          $display("%0t: stack error expected %b got %b", $time, exp_r.dropped, m_tdata[34]);
          n_err++;
        end
      end
    end
    m_tready <= calm || ($urandom_range(99) >= 35);
  end

  // watchdog: cycles in a row without any beat on either side
  always @(posedge clk) begin
    s_beat = s_tvalid && s_tready;
    m_beat = m_tvalid && m_tready;
    if (s_beat || m_beat) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  dir_row_t dir_tab [23] = '{
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'd0,        1, EvNone, 32'd0},
    '{ModeLoad,    0,   1, ChDot,   DirRight, 32'd0,        0, EvNone, 32'd0},
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'd0,        1, EvNone, 32'd0},  // pop on empty
    '{ModeRestart, 0,   0, 8'h00,   DirRight, 32'd0,        1, EvNone, 32'd0},
    '{ModeLoad,    0,   0, ChNine,  DirRight, 32'd0,        0, EvNone, 32'd0},
    '{ModeLoad,    0,   1, ChDot,   DirRight, 32'd0,        0, EvNone, 32'd0},
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'd0,        1, EvNone, 32'd0},
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'd0,        1, EvNum,  32'd9},
    '{ModeLoad,    0,   2, ChAt,    DirRight, 32'd0,        0, EvNone, 32'd0},
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'd0,        1, EvHalt, 32'd0},
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'd0,        1, EvHalt, 32'd0},  // stays halted
    '{ModeLoad,    31,  127, 8'hff, DirDown,  32'hffffffff, 1, EvNone, 32'd0},  // off-grid load
    '{ModeLoad,    24,  79, 8'hff,  DirDown,  32'd0,        1, EvNone, 32'd0},
    '{2'd3,        31,  127, 8'hff, DirDown,  32'hffffffff, 1, EvNone, 32'd0},  // unused mode
    '{ModeRestart, 0,   0, 8'h00,   DirRight, 32'd0,        1, EvNone, 32'd0},
    '{ModeLoad,    0,   0, ChAmp,   DirRight, 32'd0,        0, EvNone, 32'd0},
    '{ModeLoad,    0,   1, ChAmp,   DirRight, 32'd0,        0, EvNone, 32'd0},
    '{ModeLoad,    0,   2, ChDiv,   DirRight, 32'd0,        0, EvNone, 32'd0},
    '{ModeLoad,    0,   3, ChDot,   DirRight, 32'd0,        0, EvNone, 32'd0},
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'h80000000, 1, EvNone, 32'd0},
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'hffffffff, 1, EvNone, 32'd0},
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'd0,        0, EvNone, 32'd0},  // min / -1
    '{ModeExec,    0,   0, 8'h00,   DirRight, 32'd0,        1, EvNum,  32'h80000000}
  };

  // row_count walk: both extremes and the clamped codes
  logic [4:0] rows_plan [8] = '{5'd1, 5'd0, 5'd31, 5'd25, 5'd3, 5'd2, 5'd24, 5'd1};

  initial begin
    step_beat_t  b;
    step_res_t   tr;
    int unsigned rows;

    foreach (prog_grid[r, c]) prog_grid[r][c] = ChSpace;
    stack_cnt = 0;
    pc_c = 0;
    pc_r = 0;
    heading = DirRight;
    str_on = 1'b0;
    stopped = 1'b0;
    row_cfg = 5'd25;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      b = '{dir_tab[i].ival, dir_tab[i].rdir, dir_tab[i].val, dir_tab[i].col,
            dir_tab[i].row, dir_tab[i].mode};
      tr = '{dir_tab[i].ev, dir_tab[i].outv, 1'b0};
      send_beat(b, dir_tab[i].typed, tr);
    end

    // stack overflow: with one live row the pointer sits on (0,0) going down
    write_rows(5'd1);
    send_beat(mk_beat(ModeRestart, 0, 0, 0));
    send_beat(mk_beat(ModeLoad, 0, 0, ChV));
    send_beat(mk_beat(ModeExec, 0, 0, 0));
    send_beat(mk_beat(ModeLoad, 0, 0, ChZero + 8'd1));
    repeat (280) send_beat(mk_beat(ModeExec, 0, 0, 0));

    // random programs, each phase under its own row_count
    for (int ph = 0; ph < 19; ph++) begin
      calm = (ph >= 6 && ph < 9);
      write_rows(ph < 8 ? rows_plan[ph] : 5'($urandom_range(31)));
      rows = rows_live();
      send_beat(mk_beat(ModeRestart, 0, 0, 0));
      repeat (20) begin
        b = mk_beat(ModeLoad, 5'($urandom_range(rows > 3 ? 2 : rows - 1)),
                    7'($urandom_range(99) < 80 ? $urandom_range(15) : $urandom_range(79)),
                    pick_op());
        if ($urandom_range(99) < 8) begin
          b.row = 5'($urandom);
          b.col = 7'($urandom);
        end
        send_beat(b);
      end
      repeat (60) begin
        if (stopped && $urandom_range(1)) b = mk_beat(ModeRestart, 0, 0, 0);
        else if ($urandom_range(99) < 3) b = mk_beat(2'($urandom), 5'($urandom),
                                                     7'($urandom), 8'($urandom));
        else b = mk_beat(ModeExec, 0, 0, 0);
        send_beat(b);
      end
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    n_err += pending_res.size();
    if (n_err == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
